[hw/rtl/tiep_pkg.sv]
`timescale 1ns / 1ps
package tiep_pkg;

    localparam int OCC_W = 4;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [3:0] FMT_NONE   = 4'd0;
    localparam logic [3:0] FMT_FIXED  = 4'd1;
    localparam logic [3:0] FMT_T      = 4'd2;
    localparam logic [3:0] FMT_TV     = 4'd3;
    localparam logic [3:0] FMT_TLV    = 4'd4;
    localparam logic [3:0] FMT_TL16V  = 4'd5;
    localparam logic [3:0] FMT_TVLV   = 4'd6;
    localparam logic [3:0] FMT_SINGLE = 4'd7;
    localparam logic [3:0] FMT_GAN    = 4'd8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HDR_SHORT = 3'd1;
    localparam logic [2:0] ST_VAL_SHORT = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    localparam logic REC_ELEMENT = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] entry_tag;
        logic [3:0] entry_format;
        logic [7:0] entry_fixed_length;
        logic [7:0] lead_tag_first;
        logic [7:0] lead_tag_second;
        logic [7:0] message_byte;
    } in_item_t;

    typedef struct packed {
        logic        record_kind;
        logic [7:0]  ie_tag;
        logic [15:0] value_offset;
        logic [15:0] value_length;
        logic [1:0]  occurrence;
        logic        kept;
        logic [2:0]  status;
        logic [15:0] ie_count;
    } out_item_t;

    typedef struct packed {
        logic [3:0] format;
        logic [7:0] fixed_length;
    } fmt_entry_t;

    typedef struct packed {
        logic             en;
        logic             clr;
        logic [7:0]       tag;
        logic [OCC_W-1:0] val;
    } occ_wr_t;

endpackage

[hw/rtl/tiep_fmt_table.sv]
`timescale 1ns / 1ps
module tiep_fmt_table
    import tiep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [7:0] wr_tag,
    input  fmt_entry_t wr_entry,
    input  logic       rd_en,
    input  logic [7:0] rd_tag,
    output fmt_entry_t entry_tag,
    output fmt_entry_t entry_hi
);

    fmt_entry_t mem [256];
    logic [255:0] vld_reg;
    fmt_entry_t raw_tag_reg;
    fmt_entry_t raw_hi_reg;
    logic vld_tag_reg;
    logic vld_hi_reg;
    logic [7:0] hi_addr;

    assign hi_addr = {rd_tag[7:4], 4'h0};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_tag] <= wr_entry;
        end
        if (rd_en)
        begin
            raw_tag_reg <= mem[rd_tag];
            raw_hi_reg  <= mem[hi_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_tag_reg <= 1'b0;
            vld_hi_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_tag] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_tag_reg <= vld_reg[rd_tag];
                vld_hi_reg  <= vld_reg[hi_addr];
            end
        end
    end

    // an entry never written reads as format none
    assign entry_tag = vld_tag_reg ? raw_tag_reg : '0;
    assign entry_hi  = vld_hi_reg ? raw_hi_reg : '0;

endmodule

[hw/rtl/tiep_occ_table.sv]
`timescale 1ns / 1ps
module tiep_occ_table
    import tiep_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  occ_wr_t          wr,
    input  logic             rd_en,
    input  logic [7:0]       rd_tag,
    output logic [OCC_W-1:0] cnt_tag,
    output logic [OCC_W-1:0] cnt_hi
);

    logic [OCC_W-1:0] mem [256];
    logic [255:0] vld_reg;
    logic [OCC_W-1:0] raw_tag_reg;
    logic [OCC_W-1:0] raw_hi_reg;
    logic vld_tag_reg;
    logic vld_hi_reg;
    logic [7:0] addr_tag_reg;
    logic byp_en_reg;
    logic byp_clr_reg;
    logic [7:0] byp_tag_reg;
    logic [OCC_W-1:0] byp_val_reg;
    logic [7:0] hi_addr;

    assign hi_addr = {rd_tag[7:4], 4'h0};

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.tag] <= wr.val;
        end
        if (rd_en)
        begin
            raw_tag_reg  <= mem[rd_tag];
            raw_hi_reg   <= mem[hi_addr];
            addr_tag_reg <= rd_tag;
            byp_tag_reg  <= wr.tag;
            byp_val_reg  <= wr.val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_tag_reg <= 1'b0;
            vld_hi_reg  <= 1'b0;
            byp_en_reg  <= 1'b0;
            byp_clr_reg <= 1'b0;
        end
        else
        begin
            if (wr.clr)
            begin
                vld_reg <= '0;
            end
            else if (wr.en)
            begin
                vld_reg[wr.tag] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_tag_reg <= vld_reg[rd_tag];
                vld_hi_reg  <= vld_reg[hi_addr];
                // remember an update made at the very edge of the read
                byp_en_reg  <= wr.en;
                byp_clr_reg <= wr.clr;
            end
        end
    end

    always_comb
    begin
        if (byp_clr_reg)
        begin
            cnt_tag = '0;
            cnt_hi  = '0;
        end
        else
        begin
            if (byp_en_reg && byp_tag_reg == addr_tag_reg)
                cnt_tag = byp_val_reg;
            else
                cnt_tag = vld_tag_reg ? raw_tag_reg : '0;
            if (byp_en_reg && byp_tag_reg == {addr_tag_reg[7:4], 4'h0})
                cnt_hi = byp_val_reg;
            else
                cnt_hi = vld_hi_reg ? raw_hi_reg : '0;
        end
    end

endmodule

[hw/rtl/tiep_parse_core.sv]
`timescale 1ns / 1ps
module tiep_parse_core
    import tiep_pkg::*;
#(
    parameter int MAX_OCCURRENCES   = 4,
    parameter int MAX_MESSAGE_BYTES = 65536
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  in_item_t         item,
    input  fmt_entry_t       fmt_tag,
    input  fmt_entry_t       fmt_hi,
    input  logic [OCC_W-1:0] cnt_tag,
    input  logic [OCC_W-1:0] cnt_hi,
    input  logic [OCC_W-1:0] slots,
    output logic             res_valid,
    output out_item_t        res_item,
    output occ_wr_t          occ_wr
);

    // wide enough for the largest message limit and the 16-bit offset field
    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(MAX_OCCURRENCES);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_LEAD_LEN = 4'd1;
    localparam logic [3:0] PH_TAG      = 4'd2;
    localparam logic [3:0] PH_TLV_LEN  = 4'd3;
    localparam logic [3:0] PH_TL16_HI  = 4'd4;
    localparam logic [3:0] PH_TL16_LO  = 4'd5;
    localparam logic [3:0] PH_TVLV_L1  = 4'd6;
    localparam logic [3:0] PH_GAN_L1   = 4'd7;
    localparam logic [3:0] PH_VALUE    = 4'd8;
    localparam logic [3:0] PH_ERROR    = 4'd9;

    logic [3:0]       phase_reg, phase_next;
    logic [7:0]       tag_reg, tag_next;
    logic [15:0]      hold_reg, hold_next;
    logic [15:0]      rem_reg, rem_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] vstart_reg, vstart_next;
    logic [15:0]      ecnt_reg, ecnt_next;
    logic [2:0]       err_reg, err_next;
    logic [7:0]       lead2_reg, lead2_next;
    logic             pend_reg, pend_next;
    logic             lead_act_reg, lead_act_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             occ2_reg, occ2_next;

    logic             do_begin;
    logic [POS_W-1:0] bv_start;
    logic [15:0]      bv_len;
    logic             do_emit;
    logic [7:0]       em_tag;
    logic [POS_W-1:0] em_ofs;
    logic [15:0]      em_len;
    logic [OCC_W-1:0] em_idx;
    logic [7:0]       b;
    logic [POS_W-1:0] p1;
    logic [15:0]      rem_dec;

    assign b  = item.message_byte;
    assign p1 = pos_reg + POS_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        hold_next     = hold_reg;
        rem_next      = rem_reg;
        pos_next      = pos_reg;
        vstart_next   = vstart_reg;
        ecnt_next     = ecnt_reg;
        err_next      = err_reg;
        lead2_next    = lead2_reg;
        pend_next     = pend_reg;
        lead_act_next = lead_act_reg;
        occ_next      = occ_reg;
        occ2_next     = occ2_reg;
        do_begin      = 1'b0;
        bv_start      = '0;
        bv_len        = '0;
        do_emit       = 1'b0;
        em_tag        = '0;
        em_ofs        = '0;
        em_len        = '0;
        em_idx        = '0;
        rem_dec       = '0;
        res_valid     = 1'b0;
        res_item      = '0;
        occ_wr        = '0;

        case (item.kind)
            KIND_START:
            begin
                occ_wr.clr    = 1'b1;
                pos_next      = '0;
                ecnt_next     = '0;
                err_next      = ST_OK;
                hold_next     = '0;
                rem_next      = '0;
                vstart_next   = '0;
                lead2_next    = item.lead_tag_second;
                occ2_next     = (item.lead_tag_first != 8'd0) &&
                                (item.lead_tag_first == item.lead_tag_second);
                occ_next      = '0;
                if (item.lead_tag_first != 8'd0)
                begin
                    tag_next      = item.lead_tag_first;
                    lead_act_next = 1'b1;
                    pend_next     = (item.lead_tag_second != 8'd0);
                    phase_next    = PH_LEAD_LEN;
                end
                else if (item.lead_tag_second != 8'd0)
                begin
                    tag_next      = item.lead_tag_second;
                    lead_act_next = 1'b1;
                    pend_next     = 1'b0;
                    phase_next    = PH_LEAD_LEN;
                end
                else
                begin
                    tag_next      = '0;
                    lead_act_next = 1'b0;
                    pend_next     = 1'b0;
                    phase_next    = PH_TAG;
                end
            end
            KIND_END:
            begin
                if (phase_reg inside {PH_LEAD_LEN, PH_TLV_LEN, PH_TL16_HI, PH_TL16_LO,
                                      PH_TVLV_L1, PH_GAN_L1})
                begin
                    if (err_reg == ST_OK)
                        err_next = ST_HDR_SHORT;
                end
                else if (phase_reg == PH_VALUE)
                begin
                    if (err_reg == ST_OK)
                        err_next = ST_VAL_SHORT;
                end
                phase_next           = PH_IDLE;
                pend_next            = 1'b0;
                lead_act_next        = 1'b0;
                res_valid            = 1'b1;
                res_item.record_kind = REC_SUMMARY;
                res_item.status      = err_next;
                res_item.ie_count    = ecnt_reg;
            end
            KIND_BYTE:
            begin
                if (phase_reg != PH_IDLE && phase_reg != PH_ERROR)
                begin
                    if (pos_reg >= POS_LIMIT)
                    begin
                        if (err_reg == ST_OK)
                            err_next = ST_TOO_LONG;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        pos_next = p1;
                        case (phase_reg)
                            PH_LEAD_LEN, PH_TLV_LEN:
                            begin
                                do_begin = 1'b1;
                                bv_start = p1;
                                bv_len   = {8'd0, b};
                            end
                            PH_TAG:
                            begin
                                if (fmt_hi.format == FMT_SINGLE)
                                begin
                                    tag_next = {b[7:4], 4'h0};
                                    do_emit  = 1'b1;
                                    em_tag   = {b[7:4], 4'h0};
                                    em_ofs   = pos_reg;
                                    em_len   = 16'd1;
                                    em_idx   = cnt_hi;
                                end
                                else
                                begin
                                    tag_next = b;
                                    occ_next = cnt_tag;
                                    case (fmt_tag.format)
                                        FMT_FIXED:
                                        begin
                                            do_begin = 1'b1;
                                            bv_start = p1;
                                            bv_len   = {8'd0, fmt_tag.fixed_length};
                                        end
                                        FMT_T:
                                        begin
                                            do_emit = 1'b1;
                                            em_tag  = b;
                                            em_ofs  = pos_reg;
                                            em_len  = '0;
                                            em_idx  = cnt_tag;
                                        end
                                        FMT_TV:
                                        begin
                                            do_begin = 1'b1;
                                            bv_start = p1;
                                            bv_len   = 16'd1;
                                        end
                                        FMT_TLV:   phase_next = PH_TLV_LEN;
                                        FMT_TL16V: phase_next = PH_TL16_HI;
                                        FMT_TVLV:  phase_next = PH_TVLV_L1;
                                        FMT_GAN:   phase_next = PH_GAN_L1;
                                        default:
                                        begin
                                            if (err_reg == ST_OK)
                                                err_next = ST_UNKNOWN;
                                            phase_next = PH_ERROR;
                                        end
                                    endcase
                                end
                            end
                            PH_TL16_HI:
                            begin
                                hold_next  = {8'd0, b};
                                phase_next = PH_TL16_LO;
                            end
                            PH_TL16_LO:
                            begin
                                do_begin = 1'b1;
                                bv_start = p1;
                                bv_len   = {hold_reg[7:0], b};
                            end
                            PH_TVLV_L1:
                            begin
                                if (b[7])
                                begin
                                    do_begin = 1'b1;
                                    bv_start = p1;
                                    bv_len   = {9'd0, b[6:0]};
                                end
                                else
                                begin
                                    hold_next  = {8'd0, b};
                                    phase_next = PH_TL16_LO;
                                end
                            end
                            PH_GAN_L1:
                            begin
                                if (b[7])
                                begin
                                    hold_next  = {9'd0, b[6:0]};
                                    phase_next = PH_TL16_LO;
                                end
                                else
                                begin
                                    do_begin = 1'b1;
                                    bv_start = p1;
                                    bv_len   = {8'd0, b};
                                end
                            end
                            PH_VALUE:
                            begin
                                rem_dec  = (rem_reg != 16'd0) ? rem_reg - 16'd1 : rem_reg;
                                rem_next = rem_dec;
                                if (rem_dec == 16'd0)
                                begin
                                    do_emit = 1'b1;
                                    em_tag  = tag_reg;
                                    em_ofs  = vstart_reg;
                                    em_len  = hold_reg;
                                    em_idx  = occ_reg;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                // table loads go straight into the format table
                phase_next = phase_reg;
            end
        endcase

        if (do_begin)
        begin
            vstart_next = bv_start;
            hold_next   = bv_len;
            rem_next    = bv_len;
            if (bv_len == 16'd0)
            begin
                do_emit = 1'b1;
                em_tag  = tag_next;
                em_ofs  = bv_start;
                em_len  = '0;
                em_idx  = occ_next;
            end
            else
            begin
                phase_next = PH_VALUE;
            end
        end

        if (do_emit)
        begin
            occ_wr.en  = 1'b1;
            occ_wr.tag = em_tag;
            occ_wr.val = (em_idx < OCC_MAX) ? em_idx + OCC_W'(1) : em_idx;
            if (ecnt_reg != 16'hFFFF)
                ecnt_next = ecnt_reg + 16'd1;
            res_valid             = 1'b1;
            res_item.record_kind  = REC_ELEMENT;
            res_item.ie_tag       = em_tag;
            res_item.value_offset = em_ofs[15:0];
            res_item.value_length = em_len;
            res_item.occurrence   = (em_idx > OCC_W'(3)) ? 2'd3 : em_idx[1:0];
            res_item.kept         = (em_idx < slots);
            res_item.status       = ST_OK;
            res_item.ie_count     = ecnt_next;
            // advance to the second leading element or to tag parsing
            if (lead_act_reg && pend_reg)
            begin
                pend_next     = 1'b0;
                tag_next      = lead2_reg;
                lead_act_next = 1'b1;
                occ_next      = {{(OCC_W-1){1'b0}}, occ2_reg};
                phase_next    = PH_LEAD_LEN;
            end
            else
            begin
                lead_act_next = 1'b0;
                phase_next    = PH_TAG;
            end
        end

        if (!fire)
        begin
            res_valid = 1'b0;
            occ_wr    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tag_reg      <= '0;
            hold_reg     <= '0;
            rem_reg      <= '0;
            pos_reg      <= '0;
            vstart_reg   <= '0;
            ecnt_reg     <= '0;
            err_reg      <= ST_OK;
            lead2_reg    <= '0;
            pend_reg     <= 1'b0;
            lead_act_reg <= 1'b0;
            occ_reg      <= '0;
            occ2_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            hold_reg     <= hold_next;
            rem_reg      <= rem_next;
            pos_reg      <= pos_next;
            vstart_reg   <= vstart_next;
            ecnt_reg     <= ecnt_next;
            err_reg      <= err_next;
            lead2_reg    <= lead2_next;
            pend_reg     <= pend_next;
            lead_act_reg <= lead_act_next;
            occ_reg      <= occ_next;
            occ2_reg     <= occ2_next;
        end
    end

endmodule

[hw/rtl/tlv_information_element_parser.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_stall    in_item (in_item_t)
// out       source     out_valid / out_stall  out_item (out_item_t)
// cfg       sink       cfg_write_en           cfg_write_data (occurrence slots)
//
// One item per cycle while in_stall is low. An item is registered on acceptance together
// with its format and occurrence table reads; when the stage fires it parses the item
// and loads any result it gives into the result register.
// Reset clears the format table valid bits (all tags read as format none).
// out_stall holds the result register; the input register then holds and in_stall
// rises only while both are full.
module tlv_information_element_parser
    import tiep_pkg::*;
#(
    parameter int MAX_OCCURRENCES   = 4,
    parameter int MAX_MESSAGE_BYTES = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item,
    input  logic       cfg_write_en,
    input  logic [2:0] cfg_write_data
);

    localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(MAX_OCCURRENCES);

    logic             s1_vld_reg;
    in_item_t         s1_item_reg;
    logic             out_vld_reg;
    out_item_t        out_item_reg;
    logic [2:0]       slots_reg;
    logic [OCC_W-1:0] slots_eff;
    logic             accept;
    logic             fire;
    fmt_entry_t       fmt_tag;
    fmt_entry_t       fmt_hi;
    logic [OCC_W-1:0] cnt_tag;
    logic [OCC_W-1:0] cnt_hi;
    logic             res_valid;
    out_item_t        res_item;
    occ_wr_t          occ_wr;
    fmt_entry_t       wr_entry;

    assign fire     = s1_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = s1_vld_reg && !fire;
    assign accept   = in_valid && !in_stall;

    assign slots_eff = ({1'b0, slots_reg} > OCC_MAX) ? OCC_MAX : {1'b0, slots_reg};

    assign wr_entry.format       = in_item.entry_format;
    assign wr_entry.fixed_length = in_item.entry_fixed_length;

    tiep_fmt_table u_fmt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept && in_item.kind == KIND_LOAD),
        .wr_tag    (in_item.entry_tag),
        .wr_entry  (wr_entry),
        .rd_en     (accept),
        .rd_tag    (in_item.message_byte),
        .entry_tag (fmt_tag),
        .entry_hi  (fmt_hi)
    );

    tiep_occ_table u_occ
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (occ_wr),
        .rd_en   (accept),
        .rd_tag  (in_item.message_byte),
        .cnt_tag (cnt_tag),
        .cnt_hi  (cnt_hi)
    );

    tiep_parse_core #(
        .MAX_OCCURRENCES   (MAX_OCCURRENCES),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (s1_item_reg),
        .fmt_tag   (fmt_tag),
        .fmt_hi    (fmt_hi),
        .cnt_tag   (cnt_tag),
        .cnt_hi    (cnt_hi),
        .slots     (slots_eff),
        .res_valid (res_valid),
        .res_item  (res_item),
        .occ_wr    (occ_wr)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (fire && res_valid)
        begin
            out_item_reg <= res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            slots_reg   <= 3'd1;
        end
        else
        begin
            if (accept)
                s1_vld_reg <= 1'b1;
            else if (fire)
                s1_vld_reg <= 1'b0;
            if (fire && res_valid)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
            if (cfg_write_en)
                slots_reg <= cfg_write_data;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

    a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.record_kind == REC_SUMMARY) |->
        (out_item.ie_tag == 8'd0 && out_item.kept == 1'b0 && out_item.value_length == 16'd0))
        else $error("summary record carries element fields");

    a_element_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.record_kind == REC_ELEMENT) |->
        (out_item.status == ST_OK && out_item.ie_count != 16'd0))
        else $error("element record with bad status or count");

    a_kept_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && res_item.kept) |->
        ({2'b0, res_item.occurrence} < slots_eff))
        else $error("element kept beyond slot count");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled with free stages");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top
    import tiep_pkg::*;
();

    typedef enum int
    {
        PH_IDLE, PH_LEAD_LEN, PH_TAG, PH_TLV_LEN, PH_TL16_HI, PH_TL16_LO,
        PH_TVLV_L1, PH_GAN_L1, PH_VALUE, PH_ERROR
    } parse_phase_e;

    localparam int MAX_OCC   = 4;
    localparam int MAX_BYTES = 65536;

    class ie_scoreboard;
        logic [3:0]   fmt_tab [256];
        logic [7:0]   len_tab [256];
        int           occ_cnt [256];
        int           slots;
        parse_phase_e phase;
        int           cur_tag, hold, remain, pos, vstart, count, err, lead2;
        bit           lead2_pending, in_lead;
        out_item_t    expected_q[$];
        int           errors;

        function new();
            for (int i = 0; i < 256; i++)
            begin
                fmt_tab[i] = FMT_NONE;
                len_tab[i] = 0;
                occ_cnt[i] = 0;
            end
            slots = 1;
            phase = PH_IDLE;
            cur_tag = 0; hold = 0; remain = 0; pos = 0; vstart = 0;
            count = 0; err = ST_OK; lead2 = 0;
            lead2_pending = 0; in_lead = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void enter_lead(int tag);
            cur_tag = tag & 8'hff;
            in_lead = 1;
            phase = PH_LEAD_LEN;
        endfunction

        function void advance();
            if (in_lead && lead2_pending)
            begin
                lead2_pending = 0;
                enter_lead(lead2);
                return;
            end
            in_lead = 0;
            phase = PH_TAG;
        endfunction

        function void emit_element(int tag, int ofs, int len);
            out_item_t e;
            int        eff;
            int        idx;
            eff = (slots > MAX_OCC) ? MAX_OCC : slots;
            idx = occ_cnt[tag & 8'hff];
            if (idx < MAX_OCC)
                occ_cnt[tag & 8'hff] = idx + 1;
            if (count < 16'hffff)
                count++;
            e = '0;
            e.record_kind  = REC_ELEMENT;
            e.ie_tag       = tag[7:0];
            e.value_offset = ofs[15:0];
            e.value_length = len[15:0];
            e.occurrence   = (idx > 3) ? 2'd3 : idx[1:0];
            e.kept         = (idx < eff);
            e.status       = ST_OK;
            e.ie_count     = count[15:0];
            expected_q.push_back(e);
            advance();
        endfunction

        function void open_value(int start, int len);
            vstart = start;
            hold = len & 16'hffff;
            remain = hold;
            if (remain == 0)
                emit_element(cur_tag, vstart, 0);
            else
                phase = PH_VALUE;
        endfunction

        function void flag(int code);
            if (err == ST_OK)
                err = code;
            phase = PH_ERROR;
        endfunction

        function void take_tag(int t, int p);
            int hi;
            hi = t & 8'hf0;
            if (fmt_tab[hi] == FMT_SINGLE)
            begin
                cur_tag = hi;
                emit_element(hi, p, 1);
                return;
            end
            cur_tag = t;
            case (fmt_tab[t])
                FMT_FIXED:  open_value(p + 1, len_tab[t]);
                FMT_T:      emit_element(t, p, 0);
                FMT_TV:     open_value(p + 1, 1);
                FMT_TLV:    phase = PH_TLV_LEN;
                FMT_TL16V:  phase = PH_TL16_HI;
                FMT_TVLV:   phase = PH_TVLV_L1;
                FMT_GAN:    phase = PH_GAN_L1;
                default:    flag(ST_UNKNOWN);
            endcase
        endfunction

        function void take_byte(int b);
            int p;
            if (phase == PH_IDLE || phase == PH_ERROR)
                return;
            if (pos >= MAX_BYTES)
            begin
                flag(ST_TOO_LONG);
                return;
            end
            p = pos;
            pos++;
            case (phase)
                PH_LEAD_LEN, PH_TLV_LEN: open_value(p + 1, b);
                PH_TAG: take_tag(b, p);
                PH_TL16_HI:
                begin
                    hold = b;
                    phase = PH_TL16_LO;
                end
                PH_TL16_LO: open_value(p + 1, ((hold & 8'hff) << 8) | b);
                PH_TVLV_L1:
                begin
                    if (b & 8'h80)
                        open_value(p + 1, b & 8'h7f);
                    else
                    begin
                        hold = b;
                        phase = PH_TL16_LO;
                    end
                end
                PH_GAN_L1:
                begin
                    if (b & 8'h80)
                    begin
                        hold = b & 8'h7f;
                        phase = PH_TL16_LO;
                    end
                    else
                        open_value(p + 1, b);
                end
                PH_VALUE:
                begin
                    if (remain > 0)
                        remain--;
                    if (remain == 0)
                        emit_element(cur_tag, vstart, hold);
                end
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted input item.
        function void note_input(in_item_t it);
            out_item_t s;
            case (it.kind)
                KIND_LOAD:
                begin
                    fmt_tab[it.entry_tag] = it.entry_format;
                    len_tab[it.entry_tag] = it.entry_fixed_length;
                end
                KIND_START:
                begin
                    for (int i = 0; i < 256; i++)
                        occ_cnt[i] = 0;
                    pos = 0; count = 0; err = ST_OK; hold = 0; remain = 0;
                    vstart = 0; cur_tag = 0; in_lead = 0;
                    lead2 = it.lead_tag_second;
                    lead2_pending = (it.lead_tag_second != 0);
                    if (it.lead_tag_first != 0)
                        enter_lead(it.lead_tag_first);
                    else if (lead2_pending)
                    begin
                        lead2_pending = 0;
                        enter_lead(lead2);
                    end
                    else
                        phase = PH_TAG;
                end
                KIND_BYTE: take_byte(it.message_byte);
                default:
                begin
                    case (phase)
                        PH_LEAD_LEN, PH_TLV_LEN, PH_TL16_HI, PH_TL16_LO,
                        PH_TVLV_L1, PH_GAN_L1: flag(ST_HDR_SHORT);
                        PH_VALUE: flag(ST_VAL_SHORT);
                        default: ;
                    endcase
                    phase = PH_IDLE;
                    lead2_pending = 0;
                    in_lead = 0;
                    s = '0;
                    s.record_kind = REC_SUMMARY;
                    s.status = err[2:0];
                    s.ie_count = count[15:0];
                    expected_q.push_back(s);
                end
            endcase
        endfunction

        task check_result(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            e = expected_q.pop_front();
            if (got.record_kind !== e.record_kind)
                report($sformatf("record_kind %h exp %h", got.record_kind, e.record_kind));
            if (got.ie_tag !== e.ie_tag)
                report($sformatf("ie_tag %h exp %h", got.ie_tag, e.ie_tag));
            if (got.value_offset !== e.value_offset)
                report($sformatf("value_offset %h exp %h", got.value_offset, e.value_offset));
            if (got.value_length !== e.value_length)
                report($sformatf("value_length %h exp %h", got.value_length, e.value_length));
            if (got.occurrence !== e.occurrence)
                report($sformatf("occurrence %h exp %h", got.occurrence, e.occurrence));
            if (got.kept !== e.kept)
                report($sformatf("kept %h exp %h", got.kept, e.kept));
            if (got.status !== e.status)
                report($sformatf("status %h exp %h", got.status, e.status));
            if (got.ie_count !== e.ie_count)
                report($sformatf("ie_count %h exp %h", got.ie_count, e.ie_count));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_item;
    logic       cfg_write_en = 1'b0;
    logic [2:0] cfg_write_data = 3'd0;

    ie_scoreboard sb = new();
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    logic [3:0]   gen_fmt [256];
    logic [7:0]   gen_len [256];
    int           sent_items = 0;

    tlv_information_element_parser u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_item       (out_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send(in_item_t it);
        if (in_valid && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        if (it.kind == KIND_LOAD)
        begin
            gen_fmt[it.entry_tag] = it.entry_format;
            gen_len[it.entry_tag] = it.entry_fixed_length;
        end
        sent_items++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        // results of items that give none may still be in flight
        repeat (6) @(posedge clk);
    endtask

    task automatic write_slots(logic [2:0] v);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.slots = v;
    endtask

    function automatic in_item_t mk(logic [1:0] k, int a, int b, int c);
        in_item_t it;
        it = '0;
        it.kind = k;
        case (k)
            KIND_LOAD:
            begin
                it.entry_tag = a[7:0];
                it.entry_format = b[3:0];
                it.entry_fixed_length = c[7:0];
            end
            KIND_START:
            begin
                it.lead_tag_first = a[7:0];
                it.lead_tag_second = b[7:0];
            end
            KIND_BYTE: it.message_byte = a[7:0];
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_bytes(int n, int b);
        for (int i = 0; i < n; i++)
            send(mk(KIND_BYTE, (b < 0) ? $urandom_range(255) : b, 0, 0));
    endtask

    task automatic directed();
        send(mk(KIND_END, 0, 0, 0));
        send(mk(KIND_BYTE, 8'h10, 0, 0));
        send(mk(KIND_LOAD, 8'h10, FMT_T, 0));
        send(mk(KIND_LOAD, 8'h21, FMT_TV, 0));
        send(mk(KIND_LOAD, 8'h32, FMT_TLV, 0));
        send(mk(KIND_LOAD, 8'h43, FMT_TL16V, 0));
        send(mk(KIND_LOAD, 8'h54, FMT_TVLV, 0));
        send(mk(KIND_LOAD, 8'h60, FMT_SINGLE, 0));
        send(mk(KIND_LOAD, 8'h75, FMT_GAN, 0));
        send(mk(KIND_LOAD, 8'h86, FMT_FIXED, 2));
        send(mk(KIND_LOAD, 8'hff, FMT_FIXED, 255));
        send(mk(KIND_LOAD, 8'h90, 15, 8'hff));
        // both leads, then at least one element of every format
        send(mk(KIND_START, 8'hff, 8'h01, 0));
        send_bytes(1, 0); send_bytes(1, 1); send_bytes(1, 8'haa);
        send_bytes(1, 8'h10); send_bytes(1, 8'h10);
        send_bytes(1, 8'h21); send_bytes(1, 8'h00);
        send_bytes(1, 8'h6f);
        send_bytes(1, 8'h32); send_bytes(1, 0);
        send_bytes(1, 8'h43); send_bytes(1, 0); send_bytes(1, 1); send_bytes(1, 8'h55);
        send_bytes(1, 8'h54); send_bytes(1, 8'h81); send_bytes(1, 8'h00);
        send_bytes(1, 8'h54); send_bytes(1, 8'h00); send_bytes(1, 8'h01); send_bytes(1, 8'h00);
        send_bytes(1, 8'h75); send_bytes(1, 8'h80); send_bytes(1, 8'h01); send_bytes(1, 8'h7f);
        send_bytes(1, 8'h75); send_bytes(1, 8'h00);
        send_bytes(1, 8'h86); send_bytes(2, -1);
        send_bytes(1, 8'hff); send_bytes(255, -1);
        send(mk(KIND_END, 0, 0, 0));
        // lead with no length byte, only second lead, cut in header, cut in value, unknown
        send(mk(KIND_START, 8'h05, 8'h00, 0));
        send(mk(KIND_END, 0, 0, 0));
        send(mk(KIND_START, 8'h00, 8'h07, 0));
        send_bytes(1, 0); send_bytes(1, 8'h43); send_bytes(1, 0);
        send(mk(KIND_END, 0, 0, 0));
        send(mk(KIND_START, 0, 0, 0));
        send_bytes(1, 8'h21);
        send(mk(KIND_END, 0, 0, 0));
        send(mk(KIND_START, 0, 0, 0));
        send_bytes(1, 8'h90); send_bytes(1, 8'h10);
        send(mk(KIND_START, 0, 0, 0));
        send_bytes(1, 8'h10);
        send(mk(KIND_LOAD, 8'h10, FMT_TV, 0));
        send_bytes(2, 8'h10);
        send(mk(KIND_LOAD, 8'h10, FMT_T, 0));
        send(mk(KIND_END, 0, 0, 0));
    endtask

    // Occurrence saturates on a run of one tag.
    task automatic long_message();
        send(mk(KIND_START, 0, 0, 0));
        send_bytes(8, 8'h10);
        send(mk(KIND_END, 0, 0, 0));
    endtask

    task automatic add_element(ref int q[$]);
        int t;
        int l;
        t = ($urandom_range(9) == 0) ? $urandom_range(255) :
            ($urandom_range(8) * 16 + $urandom_range(3) * 17) & 8'hff;
        if ($urandom_range(3) == 0)
            t = {8{1'b0}} | ($urandom_range(1) ? 8'h60 + $urandom_range(15) : 8'h10);
        l = $urandom_range(5);
        q.push_back(t);
        if (gen_fmt[t & 8'hf0] == FMT_SINGLE)
            return;
        case (gen_fmt[t])
            FMT_FIXED: l = gen_len[t];
            FMT_T: return;
            FMT_TV: l = 1;
            FMT_TLV: q.push_back(l);
            FMT_TL16V:
            begin
                if ($urandom_range(19) == 0)
                    l = l + 256;
                q.push_back(l >> 8);
                q.push_back(l & 8'hff);
            end
            FMT_TVLV:
            begin
                if ($urandom_range(1))
                    q.push_back(8'h80 | l);
                else
                begin
                    q.push_back(0);
                    q.push_back(l);
                end
            end
            FMT_GAN:
            begin
                if ($urandom_range(1))
                    q.push_back(l);
                else
                begin
                    q.push_back(8'h80);
                    q.push_back(l);
                end
            end
            default: return;
        endcase
        for (int i = 0; i < l; i++)
            q.push_back($urandom_range(255));
    endtask

    task automatic random_message();
        int l1;
        int l2;
        int n;
        int q[$];
        in_item_t it;
        logic [63:0] rnd;
        if ($urandom_range(9) == 0)
        begin
            rnd = {$urandom, $urandom};
            it = rnd[$bits(in_item_t)-1:0];
            send(it);
            return;
        end
        if ($urandom_range(7) == 0)
            send(mk(KIND_LOAD, $urandom_range(255), $urandom_range(15), $urandom_range(7)));
        l1 = $urandom_range(1) ? $urandom_range(255) : 0;
        l2 = $urandom_range(1) ? $urandom_range(255) : 0;
        for (int k = 0; k < ((l1 != 0) + (l2 != 0)); k++)
        begin
            n = $urandom_range(3);
            q.push_back(n);
            for (int i = 0; i < n; i++)
                q.push_back($urandom_range(255));
        end
        n = $urandom_range(6);
        for (int i = 0; i < n; i++)
            add_element(q);
        if ($urandom_range(9) == 0 && q.size() > 0)
            q = q[0:$urandom_range(q.size() - 1)];
        send(mk(KIND_START, l1, l2, 0));
        foreach (q[i])
            send(mk(KIND_BYTE, q[i], 0, 0));
        if ($urandom_range(9) != 0)
            send(mk(KIND_END, 0, 0, 0));
    endtask

    initial
    begin
        logic [2:0] slot_list [8];
        int         goal;
        slot_list = '{3'd0, 3'd7, 3'd4, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6};
        for (int i = 0; i < 256; i++)
        begin
            gen_fmt[i] = FMT_NONE;
            gen_len[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        long_message();
        drain();
        for (int ph = 0; ph < 8; ph++)
        begin
            write_slots(slot_list[ph]);
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 49 : 0;
            stall_pct = (ph % 4 == 2) ? 49 : 0;
            if (ph % 4 == 3)
            begin
                send_idle_pct = 14;
                stall_pct = 14;
            end
            goal = sent_items + 85;
            while (sent_items < goal)
            begin
                random_message();
                // hold off until every result is back once
                if (ph == 2 && sent_items > goal - 60 && sent_items < goal - 50)
                    drain();
            end
            drain();
        end
        stall_pct = 0;
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tiep_pkg.sv
hw/rtl/tiep_fmt_table.sv
hw/rtl/tiep_occ_table.sv
hw/rtl/tiep_parse_core.sv
hw/rtl/tlv_information_element_parser.sv
test/tb_top.sv
